// ----- rtl/core/xfve_pkg.sv -----
// Package for the XOR float value encoder.
// Field widths, header codes and the shared result and window types.
// No dependencies.
package xfve_pkg;

   localparam int WORD_BITS           = 64;
   localparam int LEAD_FIELD_BITS     = 5;
   localparam int LEN_FIELD_BITS      = 6;
   localparam int DEF_MAX_LEAD_ZEROS  = 31;
   localparam int HDR_BITS            = 2 + LEAD_FIELD_BITS + LEN_FIELD_BITS;
   localparam int HDR_LEN_BITS        = 4;
   localparam int PLEN_BITS           = 7;

   // header codes, right-aligned
   localparam logic [HDR_BITS-1:0]     HDR_UNCHANGED     = '0;
   localparam logic [HDR_LEN_BITS-1:0] HDR_UNCHANGED_LEN = 4'd1;
   localparam logic [HDR_BITS-1:0]     HDR_REUSE         = 13'd3;
   localparam logic [HDR_LEN_BITS-1:0] HDR_REUSE_LEN     = 4'd2;
   localparam logic [1:0]              HDR_NEW_PREFIX    = 2'b10;
   localparam logic [HDR_LEN_BITS-1:0] HDR_NEW_LEN       = 4'(HDR_BITS);

   typedef struct packed {
      logic [HDR_BITS-1:0]     header_bits;
      logic [HDR_LEN_BITS-1:0] header_length;
      logic [WORD_BITS-1:0]    payload;
      logic [PLEN_BITS-1:0]    payload_length;
   } result_type;

   typedef struct packed {
      logic [LEAD_FIELD_BITS-1:0] lead;
      logic [LEN_FIELD_BITS-1:0]  trail;
   } window_type;

endpackage

// ----- rtl/core/xfve_encode.sv -----
// Combinational encode step: XOR with previous value, zero counts,
// form selection, block extraction and next window. Uses xfve_pkg.
module xfve_encode import xfve_pkg::*; #(
   parameter int MAX_LEAD_ZEROS = DEF_MAX_LEAD_ZEROS
) (
   input  logic [WORD_BITS-1:0] sample,
   input  logic                 start_req,
   input  logic [WORD_BITS-1:0] prev_sample,
   input  window_type           window,
   output result_type           result,
   output window_type           window_next
);

   function automatic logic [PLEN_BITS-1:0] count_lead(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] v;
      logic [PLEN_BITS-1:0] n;
      v = x;
      n = '0;
      if (v[63:32] == '0) begin n = n + 7'd32; v = {v[31:0], 32'b0}; end
      if (v[63:48] == '0) begin n = n + 7'd16; v = {v[47:0], 16'b0}; end
      if (v[63:56] == '0) begin n = n + 7'd8;  v = {v[55:0], 8'b0};  end
      if (v[63:60] == '0) begin n = n + 7'd4;  v = {v[59:0], 4'b0};  end
      if (v[63:62] == '0) begin n = n + 7'd2;  v = {v[61:0], 2'b0};  end
      if (!v[63]) begin n = n + 7'd1; v = {v[62:0], 1'b0}; end
      if (!v[63]) begin n = n + 7'd1; end
      return n;
   endfunction

   function automatic logic [WORD_BITS-1:0] bit_reverse(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] r;
      for (int i = 0; i < WORD_BITS; i++) begin
         r[i] = x[WORD_BITS-1-i];
      end
      return r;
   endfunction

   localparam logic [LEAD_FIELD_BITS-1:0] LEAD_CLAMP = LEAD_FIELD_BITS'(MAX_LEAD_ZEROS);

   logic [WORD_BITS-1:0]       eff_prev;
   window_type                 eff_win;
   logic [WORD_BITS-1:0]       diff;
   logic [PLEN_BITS-1:0]       lead_raw;
   logic [PLEN_BITS-1:0]       trail_raw;
   logic [LEAD_FIELD_BITS-1:0] lead;
   logic [LEN_FIELD_BITS-1:0]  trail;
   logic [PLEN_BITS-1:0]       block;
   logic signed [7:0]          prev_block;
   logic [PLEN_BITS-1:0]       prev_len;
   logic                       reuse;
   logic [LEN_FIELD_BITS-1:0]  shift_amt;
   logic [PLEN_BITS-1:0]       keep_len;
   logic [WORD_BITS-1:0]       extracted;
   logic [LEN_FIELD_BITS-1:0]  block_m1;

   always_comb begin
      eff_prev  = start_req ? '0 : prev_sample;
      eff_win   = start_req ? '0 : window;
      diff      = sample ^ eff_prev;
      lead_raw  = count_lead(diff);
      trail_raw = count_lead(bit_reverse(diff));
      lead      = (lead_raw > PLEN_BITS'(LEAD_CLAMP)) ? LEAD_CLAMP
                                                     : lead_raw[LEAD_FIELD_BITS-1:0];
      trail     = trail_raw[LEN_FIELD_BITS-1:0];
      block     = 7'd64 - PLEN_BITS'(lead) - PLEN_BITS'(trail);
      prev_block = 8'sd64 - $signed({3'b0, eff_win.lead}) - $signed({2'b0, eff_win.trail});
      prev_len  = (prev_block < 8'sd0) ? '0 : prev_block[PLEN_BITS-1:0];
      reuse     = (lead >= eff_win.lead) && (trail >= eff_win.trail)
                  && (prev_block < $signed(8'(LEN_FIELD_BITS) + {1'b0, block}));
      shift_amt = reuse ? eff_win.trail : trail;
      keep_len  = reuse ? prev_len : block;
      extracted = (diff >> shift_amt) & ~({WORD_BITS{1'b1}} << keep_len);
      block_m1  = LEN_FIELD_BITS'(block - 7'd1);

      window_next = eff_win;
      if (diff == '0) begin
         result.header_bits    = HDR_UNCHANGED;
         result.header_length  = HDR_UNCHANGED_LEN;
         result.payload        = '0;
         result.payload_length = '0;
      end else if (reuse) begin
         result.header_bits    = HDR_REUSE;
         result.header_length  = HDR_REUSE_LEN;
         result.payload        = extracted;
         result.payload_length = prev_len;
      end else begin
         result.header_bits    = {HDR_NEW_PREFIX, lead, block_m1};
         result.header_length  = HDR_NEW_LEN;
         result.payload        = extracted;
         result.payload_length = block;
         window_next.lead      = lead;
         window_next.trail     = trail;
      end
   end

endmodule

// ----- rtl/core/xor_float_value_encoder.sv -----
// Top level of the XOR float value encoder: handshake, input and result
// registers, stream state. Uses xfve_pkg and xfve_encode.
//
//  channel | ports                                        | direction
//  req     | req_valid/ready, req_sample, req_start_req   | in
//  rsp     | rsp_valid/ready, rsp_header_bits/_length,    | out
//          | rsp_payload, rsp_payload_length              |
//
// One transaction per clock sustained while rsp_ready holds; rsp valid once the
// accepted req has gone through the input register, then the encode logic into the result register.
// The stream state updates when a transaction leaves the input register.
// Synchronous reset clears valids, previous value and window.
// A stalled rsp holds one result while one more transaction waits in the
// input register; req_ready drops only when both are full.
module xor_float_value_encoder import xfve_pkg::*; #(
   parameter int MAX_LEAD_ZEROS = DEF_MAX_LEAD_ZEROS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [WORD_BITS-1:0]    req_sample,
   input  logic                    req_start_req,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [HDR_BITS-1:0]     rsp_header_bits,
   output logic [HDR_LEN_BITS-1:0] rsp_header_length,
   output logic [WORD_BITS-1:0]    rsp_payload,
   output logic [PLEN_BITS-1:0]    rsp_payload_length
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [WORD_BITS-1:0] s1_sample_ff;
   logic                 s1_start_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_result_ff;
   logic [WORD_BITS-1:0] prev_sample_ff;
   window_type           window_ff;
   result_type           enc_result;
   window_type           enc_window;
   logic                 out_free;
   logic                 s1_move;
   logic                 req_take;

   xfve_encode #(
      .MAX_LEAD_ZEROS(MAX_LEAD_ZEROS)
   ) u_encode (
      .sample      (s1_sample_ff),
      .start_req   (s1_start_ff),
      .prev_sample (prev_sample_ff),
      .window      (window_ff),
      .result      (enc_result),
      .window_next (enc_window)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      s1_move      = s1_valid_ff && out_free;
      req_ready    = !s1_valid_ff || out_free;
      req_take     = req_valid && req_ready;
      s1_valid_in  = req_take || (s1_valid_ff && !out_free);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_sample_ff <= '0;
         window_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            prev_sample_ff <= s1_sample_ff;
            window_ff      <= enc_window;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_sample;
         s1_start_ff  <= req_start_req;
      end
      if (s1_move) begin
         rsp_result_ff <= enc_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_header_bits    = rsp_result_ff.header_bits;
   assign rsp_header_length  = rsp_result_ff.header_length;
   assign rsp_payload        = rsp_result_ff.payload;
   assign rsp_payload_length = rsp_result_ff.payload_length;

endmodule

// ----- sim/xor_float_value_encoder_tb.sv -----
// Testbench for xor_float_value_encoder: a directed table, then random value streams.
// Results are checked against pinned codes or an in-bench XOR/window predictor.
// Depends on xfve_pkg and the xor_float_value_encoder RTL.
module xor_float_value_encoder_tb;
   import xfve_pkg::*;

   typedef struct packed {
      logic [WORD_BITS-1:0] sample;
      logic                 start;
      bit                   pinned;
      result_type           code;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam int ITEMS_PER_STAGE = 445;
   localparam int HOLD_CYCLES = 300;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{64'h0, 1'b0, 1'b1, '{HDR_UNCHANGED, HDR_UNCHANGED_LEN, 64'h0, 7'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
        '{HDR_REUSE, HDR_REUSE_LEN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
        '{HDR_UNCHANGED, HDR_UNCHANGED_LEN, 64'h0, 7'd0}},
      '{64'h0, 1'b1, 1'b1, '{HDR_UNCHANGED, HDR_UNCHANGED_LEN, 64'h0, 7'd0}},
      '{64'h1, 1'b1, 1'b1, '{{HDR_NEW_PREFIX, 5'd31, 6'd32}, HDR_NEW_LEN, 64'h1, 7'd33}},
      '{64'h8000_0000_0000_0001, 1'b0, 1'b1,
        '{{HDR_NEW_PREFIX, 5'd0, 6'd0}, HDR_NEW_LEN, 64'h1, 7'd1}},
      '{64'h8000_0000_0000_0001, 1'b0, 1'b1,
        '{HDR_UNCHANGED, HDR_UNCHANGED_LEN, 64'h0, 7'd0}},
      '{64'h0, 1'b0, 1'b1,
        '{{HDR_NEW_PREFIX, 5'd0, 6'd63}, HDR_NEW_LEN, 64'h8000_0000_0000_0001, 7'd64}},
      '{64'h4000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h6000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h00FF_0000_0000_0000, 1'b1, 1'b0, '0},
      '{64'h00E7_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h00E7_0000_0000_0001, 1'b0, 1'b0, '0},
      '{64'h0, 1'b0, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
        '{HDR_REUSE, HDR_REUSE_LEN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64}},
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
      '{64'h3FF0_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h4000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h0000_0001_0000_0000, 1'b0, 1'b0, '0},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [WORD_BITS-1:0]    req_sample = '0;
   logic                    req_start_req = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [HDR_BITS-1:0]     rsp_header_bits;
   logic [HDR_LEN_BITS-1:0] rsp_header_length;
   logic [WORD_BITS-1:0]    rsp_payload;
   logic [PLEN_BITS-1:0]    rsp_payload_length;

   // predictor state
   logic [WORD_BITS-1:0]       last_sample = '0;
   logic [LEAD_FIELD_BITS-1:0] win_lead = '0;
   logic [LEN_FIELD_BITS-1:0]  win_trail = '0;

   logic [WORD_BITS-1:0] stream_sample = '0;
   stim_row_type         offered_rows [$];
   result_type           pending_codes [$];
   int                   mismatch_count = 0;
   int                   tx_idle_pct = 0;
   int                   rx_idle_pct = 0;
   int                   stage = 0;
   logic                 rsp_hold = 1'b0;

   xor_float_value_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_start_req      (req_start_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_header_bits    (rsp_header_bits),
      .rsp_header_length  (rsp_header_length),
      .rsp_payload        (rsp_payload),
      .rsp_payload_length (rsp_payload_length)
   );

   always #4 clock = ~clock;

   function automatic logic [WORD_BITS-1:0] field_mask(input int bits);
      if (bits >= WORD_BITS) return '1;
      return (64'd1 << bits) - 64'd1;
   endfunction

   function automatic result_type predict_encoding(input logic [WORD_BITS-1:0] sample,
                                                   input logic start);
      logic [WORD_BITS-1:0] diff;
      int lead;
      int trail;
      int blk;
      int win_blk;
      result_type code;
      if (start) begin
         last_sample = '0;
         win_lead = '0;
         win_trail = '0;
      end
      diff = sample ^ last_sample;
      code = '0;
      code.header_bits = HDR_UNCHANGED;
      code.header_length = HDR_UNCHANGED_LEN;
      if (diff != '0) begin
         lead = 0;
         while (!diff[WORD_BITS-1-lead]) lead++;
         trail = 0;
         while (!diff[trail]) trail++;
         if (lead > DEF_MAX_LEAD_ZEROS) lead = DEF_MAX_LEAD_ZEROS;
         blk = WORD_BITS - lead - trail;
         win_blk = WORD_BITS - int'(win_lead) - int'(win_trail);
         if (lead >= int'(win_lead) && trail >= int'(win_trail)
             && win_blk < LEN_FIELD_BITS + blk) begin
            code.header_bits = HDR_REUSE;
            code.header_length = HDR_REUSE_LEN;
            code.payload = (diff >> win_trail) & field_mask(win_blk);
            code.payload_length = PLEN_BITS'(win_blk);
         end else begin
            code.header_bits = {HDR_NEW_PREFIX, LEAD_FIELD_BITS'(lead),
                                LEN_FIELD_BITS'(blk - 1)};
            code.header_length = HDR_NEW_LEN;
            code.payload = (diff >> trail) & field_mask(blk);
            code.payload_length = PLEN_BITS'(blk);
            win_lead = LEAD_FIELD_BITS'(lead);
            win_trail = LEN_FIELD_BITS'(trail);
         end
      end
      last_sample = sample;
      return code;
   endfunction

   // mostly related values of one stream, with restarts and some noise
   function automatic stim_row_type make_stream_row();
      int pick;
      int lo;
      int hi;
      stim_row_type row;
      pick = $urandom_range(0, 99);
      lo = $urandom_range(0, 63);
      hi = $urandom_range(lo, 63);
      row = '0;
      if (pick < 6) begin
         row.start = 1'b1;
         row.sample = {$urandom, $urandom} & field_mask($urandom_range(0, 64));
      end else if (pick < 18) begin
         row.sample = stream_sample;
      end else if (pick < 70) begin
         row.sample = stream_sample ^ ({$urandom, $urandom} & (field_mask(hi - lo + 1) << lo));
      end else if (pick < 80) begin
         row.sample = {$urandom, $urandom} & field_mask($urandom_range(1, 32));
      end else if (pick < 90) begin
         row.sample = stream_sample ^ (64'd1 << lo);
      end else begin
         row.sample = {$urandom, $urandom};
      end
      stream_sample = row.sample;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                  input logic [WORD_BITS-1:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   task automatic send_row(input stim_row_type row);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      offered_rows.push_back(row);
      req_valid <= 1'b1;
      req_sample <= row.sample;
      req_start_req <= row.start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_codes.size() != 0);
   endtask

   always @(posedge clock) begin
      stim_row_type row;
      result_type code;
      if (!reset && req_valid && req_ready) begin
         row = offered_rows.pop_front();
         code = predict_encoding(req_sample, req_start_req);
         pending_codes.push_back(row.pinned ? row.code : code);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch("unexpected transaction, payload", rsp_payload, '0);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_header_bits !== want.header_bits)
               report_mismatch("header_bits", WORD_BITS'(rsp_header_bits),
                               WORD_BITS'(want.header_bits));
            if (rsp_header_length !== want.header_length)
               report_mismatch("header_length", WORD_BITS'(rsp_header_length),
                               WORD_BITS'(want.header_length));
            if (rsp_payload !== want.payload)
               report_mismatch("payload", rsp_payload, want.payload);
            if (rsp_payload_length !== want.payload_length)
               report_mismatch("payload_length", WORD_BITS'(rsp_payload_length),
                               WORD_BITS'(want.payload_length));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // long receiver stall while the sender keeps offering
   initial begin
      wait (stage == 3);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #(8 * 400000);
      $display("xor_float_value_encoder_tb failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle_pct = 20;
      rx_idle_pct = 60;
      for (int i = 0; i < DIRECTED_ROWS; i++) send_row(DIRECTED[i]);
      settle_results();
      for (stage = 1; stage <= 3; stage++) begin
         tx_idle_pct = (stage == 1) ? 20 : (stage == 2) ? 60 : 0;
         rx_idle_pct = (stage == 1) ? 60 : (stage == 2) ? 20 : 0;
         for (int i = 0; i < ITEMS_PER_STAGE; i++) send_row(make_stream_row());
         settle_results();
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("xor_float_value_encoder_tb passed");
      end else begin
         $display("xor_float_value_encoder_tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/xfve_pkg.sv
rtl/core/xfve_encode.sv
rtl/core/xor_float_value_encoder.sv
sim/xor_float_value_encoder_tb.sv
